>>> design/config_text_lexer_assert.svh
// ----------------------------------------------------------------------------
// config_text_lexer_assert.svh
// Assertion macros shared by the lexer modules.
// ----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_LEXER_ASSERT_SVH
`define CONFIG_TEXT_LEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

>>> design/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// Types, codes, character constants and classifiers of the text lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctl_pkg;

    localparam int LINE_BITS_DEF  = 24;
    localparam int VALUE_BITS_DEF = 31;
    // Result bits other than the value and line fields.
    localparam int RES_FIXED_W    = 17;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef enum logic [2:0] {
        EV_BYTE = 3'd0,
        EV_END  = 3'd1,
        EV_SEMI = 3'd2,
        EV_ERR  = 3'd3,
        EV_EOS  = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        TK_INT   = 2'd0,
        TK_DEC   = 2'd1,
        TK_IDENT = 2'd2,
        TK_STR   = 2'd3
    } token_t;

    typedef enum logic [2:0] {
        ERR_UNEXPECTED  = 3'd0,
        ERR_AFTER_NUM   = 3'd1,
        ERR_AFTER_IDENT = 3'd2,
        ERR_AFTER_STR   = 3'd3,
        ERR_UNTERM_STR  = 3'd4
    } error_t;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_INT       = 10'b00_0000_0010,
        ST_DEC       = 10'b00_0000_0100,
        ST_IDENT     = 10'b00_0000_1000,
        ST_STR_DQ    = 10'b00_0001_0000,
        ST_STR_SQ    = 10'b00_0010_0000,
        ST_AFTER_STR = 10'b00_0100_0000,
        ST_COMMENT   = 10'b00_1000_0000,
        ST_ERROR     = 10'b01_0000_0000,
        ST_DONE      = 10'b10_0000_0000
    } mode_t;

    function automatic logic is_dig(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_let(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

`default_nettype wire

>>> design/ctl_if.sv
// ----------------------------------------------------------------------------
// ctl_if
// Character input channel and lexer event channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ctl_event_if #(
    parameter int LINE_BITS  = ctl_pkg::LINE_BITS_DEF,
    parameter int VALUE_BITS = ctl_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            event_kind;
    logic [1:0]            token_kind;
    logic [7:0]            byte_out;
    logic [VALUE_BITS-1:0] int_value;
    logic [LINE_BITS-1:0]  line_number;
    logic [2:0]            error_code;
    logic                  last_of_run;

    modport source (output valid, event_kind, token_kind, byte_out, int_value,
                    line_number, error_code, last_of_run, input ready);
    modport sink   (input valid, event_kind, token_kind, byte_out, int_value,
                    line_number, error_code, last_of_run, output ready);
endinterface

`default_nettype wire

>>> design/ctl_lex_core.sv
// ----------------------------------------------------------------------------
// ctl_lex_core
// Lexer state and the up to two results caused by one character.
// ----------------------------------------------------------------------------
`default_nettype none
`include "config_text_lexer_assert.svh"

module ctl_lex_core #(
    parameter int LINE_BITS  = ctl_pkg::LINE_BITS_DEF,
    parameter int VALUE_BITS = ctl_pkg::VALUE_BITS_DEF,
    parameter int RES_W      = LINE_BITS + VALUE_BITS + ctl_pkg::RES_FIXED_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       text_byte,
    input  wire logic             end_of_text,
    output logic [RES_W-1:0]      res0,
    output logic [RES_W-1:0]      res1,
    output logic [1:0]            res_count
);
    import ctl_pkg::*;

    typedef struct packed {
        event_t                ev;
        token_t                kind;
        logic [7:0]            chr;
        logic [VALUE_BITS-1:0] value;
        logic [LINE_BITS-1:0]  line;
        error_t                err;
        logic                  last;
    } res_t;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

    mode_t                 mode_reg, mode_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    error_t                err_reg, err_next;

    res_t                  r0, r1;
    logic [1:0]            n;
    logic                  newline;
    logic                  do_delim, do_raise;
    token_t                delim_kind;
    logic [VALUE_BITS-1:0] delim_val;
    error_t                delim_err, raise_code;
    logic [VALUE_BITS+3:0] acc_x10;
    logic [3:0]            digit;
    logic                  is_d, is_l, is_w;

    assign digit   = text_byte[3:0] - CH_ZERO[3:0];
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + {{VALUE_BITS{1'b0}}, digit};
    assign is_d    = is_dig(text_byte);
    assign is_l    = is_let(text_byte);
    assign is_w    = is_ws(text_byte);

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        newline    = 1'b0;
        n          = 2'd0;
        do_delim   = 1'b0;
        do_raise   = 1'b0;
        delim_kind = TK_INT;
        delim_val  = '0;
        delim_err  = ERR_AFTER_NUM;
        raise_code = ERR_UNEXPECTED;
        r0         = '{ev: EV_BYTE, kind: TK_INT, chr: 8'd0, value: '0,
                       line: line_reg, err: ERR_UNEXPECTED, last: 1'b0};
        r1         = r0;

        case (mode_reg)
            ST_INT:
            begin
                if (!end_of_text && is_d)
                begin
                    if (acc_x10 > {4'b0, VALUE_MAX})
                        acc_next = VALUE_MAX;
                    else
                        acc_next = acc_x10[VALUE_BITS-1:0];
                    r0.chr = text_byte;
                    n      = 2'd1;
                end
                else if (!end_of_text && text_byte == CH_DOT)
                begin
                    r0.kind   = TK_DEC;
                    r0.chr    = text_byte;
                    n         = 2'd1;
                    mode_next = ST_DEC;
                end
                else
                begin
                    do_delim  = 1'b1;
                    delim_val = acc_reg;
                end
            end
            ST_DEC:
            begin
                if (!end_of_text && is_d)
                begin
                    r0.kind = TK_DEC;
                    r0.chr  = text_byte;
                    n       = 2'd1;
                end
                else
                begin
                    do_delim   = 1'b1;
                    delim_kind = TK_DEC;
                end
            end
            ST_IDENT:
            begin
                if (!end_of_text && (is_l || is_d || text_byte == CH_USCORE))
                begin
                    r0.kind = TK_IDENT;
                    r0.chr  = text_byte;
                    n       = 2'd1;
                end
                else
                begin
                    do_delim   = 1'b1;
                    delim_kind = TK_IDENT;
                    delim_err  = ERR_AFTER_IDENT;
                end
            end
            ST_STR_DQ, ST_STR_SQ:
            begin
                if (end_of_text)
                begin
                    do_raise   = 1'b1;
                    raise_code = ERR_UNTERM_STR;
                end
                else if (text_byte == ((mode_reg == ST_STR_DQ) ? CH_DQUOTE : CH_SQUOTE))
                    mode_next = ST_AFTER_STR;
                else
                begin
                    r0.kind = TK_STR;
                    r0.chr  = text_byte;
                    n       = 2'd1;
                end
            end
            ST_AFTER_STR:
            begin
                do_delim   = 1'b1;
                delim_kind = TK_STR;
                delim_err  = ERR_AFTER_STR;
            end
            ST_COMMENT:
            begin
                if (end_of_text)
                begin
                    r0.ev     = EV_EOS;
                    n         = 2'd1;
                    mode_next = ST_DONE;
                end
                else if (text_byte == CH_NL)
                begin
                    newline   = 1'b1;
                    mode_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                r0.ev  = EV_ERR;
                r0.err = err_reg;
                n      = 2'd1;
            end
            ST_DONE:
            begin
                r0.ev = EV_EOS;
                n     = 2'd1;
            end
            default:
            begin
                if (end_of_text)
                begin
                    r0.ev     = EV_EOS;
                    n         = 2'd1;
                    mode_next = ST_DONE;
                end
                else if (text_byte == CH_SEMI)
                begin
                    r0.ev     = EV_SEMI;
                    n         = 2'd1;
                    mode_next = ST_IDLE;
                end
                else if (is_d)
                begin
                    acc_next  = {{(VALUE_BITS-4){1'b0}}, digit};
                    r0.chr    = text_byte;
                    n         = 2'd1;
                    mode_next = ST_INT;
                end
                else if (text_byte == CH_DQUOTE)
                    mode_next = ST_STR_DQ;
                else if (text_byte == CH_SQUOTE)
                    mode_next = ST_STR_SQ;
                else if (is_l)
                begin
                    r0.kind   = TK_IDENT;
                    r0.chr    = text_byte;
                    n         = 2'd1;
                    mode_next = ST_IDENT;
                end
                else if (text_byte == CH_HASH)
                    mode_next = ST_COMMENT;
                else if (is_w)
                begin
                    newline   = (text_byte == CH_NL);
                    mode_next = ST_IDLE;
                end
                else
                    do_raise = 1'b1;
            end
        endcase

        // An open token is closed by end of text, ';' or whitespace.
        if (do_delim)
        begin
            r0.ev    = EV_END;
            r0.kind  = delim_kind;
            r0.value = delim_val;
            if (end_of_text)
            begin
                r1.ev     = EV_EOS;
                n         = 2'd2;
                mode_next = ST_DONE;
            end
            else if (text_byte == CH_SEMI)
            begin
                r1.ev     = EV_SEMI;
                n         = 2'd2;
                mode_next = ST_IDLE;
            end
            else if (is_w)
            begin
                n         = 2'd1;
                newline   = (text_byte == CH_NL);
                mode_next = ST_IDLE;
            end
            else
            begin
                do_raise   = 1'b1;
                raise_code = delim_err;
            end
        end

        if (do_raise)
        begin
            r0        = '{ev: EV_ERR, kind: TK_INT, chr: 8'd0, value: '0,
                          line: line_reg, err: raise_code, last: 1'b0};
            n         = 2'd1;
            err_next  = raise_code;
            mode_next = ST_ERROR;
        end

        if (n == 2'd1)
            r0.last = 1'b1;
        r1.last = 1'b1;

        line_next = (newline && line_reg != LINE_MAX) ? line_reg + 1'b1 : line_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ST_IDLE;
            acc_reg  <= '0;
            line_reg <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            err_reg  <= ERR_UNEXPECTED;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            line_reg <= line_next;
            err_reg  <= err_next;
        end
    end

    assign res0      = r0;
    assign res1      = r1;
    assign res_count = n;

    `CTL_ASSERT_NOW(a_line_nonzero, 1'b1, line_reg != '0)
    `CTL_ASSERT_NEXT(a_error_sticky, mode_reg == ST_ERROR, mode_reg == ST_ERROR)
    `CTL_ASSERT_NEXT(a_done_sticky, mode_reg == ST_DONE, mode_reg == ST_DONE)
    `CTL_ASSERT_NOW(a_pair_is_delim, step && n == 2'd2,
                    r0.ev == EV_END && (r1.ev == EV_EOS || r1.ev == EV_SEMI))

endmodule

`default_nettype wire

>>> design/ctl_result_fifo.sv
// ----------------------------------------------------------------------------
// ctl_result_fifo
// Small result queue that takes up to two entries and gives one per cycle when popped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "config_text_lexer_assert.svh"

module ctl_result_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_count,
    input  wire logic [WIDTH-1:0] push0,
    input  wire logic [WIDTH-1:0] push1,
    output logic                  space,
    output logic                  out_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      out_data
);
    import ctl_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign out_valid = (count_reg != '0);
    assign do_pop    = pop && out_valid;
    assign space     = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_data  = mem_reg[rptr_reg];

    assign wptr_next  = wptr_reg + PTR_W'(push_count);
    assign rptr_next  = rptr_reg + PTR_W'(do_pop);
    assign count_next = count_reg + CNT_W'(push_count) - CNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wptr_reg + PTR_W'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `CTL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `CTL_ASSERT_NOW(a_push_has_room, push_count != 2'd0, space)
    `CTL_ASSERT_NEXT(a_drain_empty, do_pop && push_count == 2'd0 && count_reg == CNT_W'(1),
                     !out_valid)

endmodule

`default_nettype wire

>>> design/config_text_lexer.sv
// ----------------------------------------------------------------------------
// config_text_lexer
// Character-stream lexer for a small configuration language.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one text character, or an end-of-text mark, per
//   transaction. events carries the lexer results: token bytes, token
//   ends, semicolons, errors and end of stream, each with the line number
//   as it stood before the character and a last_of_run flag.
//   A character is lexed in the cycle it is accepted and its results are
//   shown on events from the next cycle on at the earliest.
//   The block accepts one character per cycle while the result queue has
//   room for two more entries; a character that ends a token before ';' or
//   end of text causes two results, which drain one per cycle while the
//   receiver is ready, through the four-entry result queue.
//   When the receiver stalls, results wait in the queue and chars.ready
//   drops once fewer than two entries are free.
//   Reset empties the queue, returns the lexer to its idle mode with the
//   line counter at one and clears the held error.
// ----------------------------------------------------------------------------
`default_nettype none

module config_text_lexer #(
    parameter int LINE_BITS  = ctl_pkg::LINE_BITS_DEF,
    parameter int VALUE_BITS = ctl_pkg::VALUE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctl_char_if.sink   chars,
    ctl_event_if.source events
);
    import ctl_pkg::*;

    localparam int RES_W = LINE_BITS + VALUE_BITS + RES_FIXED_W;

    typedef struct packed {
        event_t                ev;
        token_t                kind;
        logic [7:0]            chr;
        logic [VALUE_BITS-1:0] value;
        logic [LINE_BITS-1:0]  line;
        error_t                err;
        logic                  last;
    } res_t;

    logic [RES_W-1:0] res0, res1, head;
    logic [1:0]       res_count, push_count;
    logic             step, space;
    res_t             head_res;

    assign step       = chars.valid && space;
    assign chars.ready = space;
    assign push_count = step ? res_count : 2'd0;

    ctl_lex_core #(
        .LINE_BITS  (LINE_BITS),
        .VALUE_BITS (VALUE_BITS),
        .RES_W      (RES_W)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_byte   (chars.text_byte),
        .end_of_text (chars.end_of_text),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    ctl_result_fifo #(
        .WIDTH (RES_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .space      (space),
        .out_valid  (events.valid),
        .pop        (events.ready),
        .out_data   (head)
    );

    assign head_res           = head;
    assign events.event_kind  = head_res.ev;
    assign events.token_kind  = head_res.kind;
    assign events.byte_out    = head_res.chr;
    assign events.int_value   = head_res.value;
    assign events.line_number = head_res.line;
    assign events.error_code  = head_res.err;
    assign events.last_of_run = head_res.last;

endmodule

`default_nettype wire

>>> tb/tb_config_text_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_config_text_lexer
// Sends a short directed character stream and about a thousand random
// characters, built mostly from well-formed tokens, then a random
// ending (end of text or one kind of fault) and some trailing characters.
// Each lexer result is checked against a behavioral model or preset fields.
// ----------------------------------------------------------------------------
module tb_config_text_lexer;
    import ctl_pkg::*;

    localparam int VW           = VALUE_BITS_DEF;
    localparam int LW           = LINE_BITS_DEF;
    localparam int RANDOM_ITEMS = 1150;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [VW-1:0] VALUE_MAX  = '1;
    localparam logic [LW-1:0] LINE_MAX   = '1;
    localparam logic [LW-1:0] FIRST_LINE = 1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Token and error fields read as zero on events that do not use them.
    localparam token_t NO_TOKEN = TK_INT;
    localparam error_t NO_ERR   = ERR_UNEXPECTED;

    typedef enum int {
        GEN_INT, GEN_DEC, GEN_IDENT, GEN_DQ, GEN_SQ, GEN_COMMENT, GEN_NONE
    } gen_kind_t;

    typedef struct {
        event_t        kind;
        token_t        tok;
        logic [7:0]    text;
        logic [VW-1:0] value;
        logic [LW-1:0] line;
        error_t        err;
        logic          last;
    } lex_result_t;

    typedef struct {
        logic [7:0]  ch;
        logic        eot;
        bit          typed;
        int          n_typed;
        lex_result_t typed_res [2];
    } char_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ctl_char_if  char_bus ();
    ctl_event_if event_bus ();

    config_text_lexer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_bus),
        .events (event_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Lexer model state.
    mode_t         lex_mode_q = ST_IDLE;
    logic [VW-1:0] number_acc = '0;
    logic [LW-1:0] line_count = FIRST_LINE;
    error_t        held_err   = NO_ERR;
    logic [LW-1:0] line_before;

    lex_result_t step_out [$];
    lex_result_t expected_results [$];
    char_row_t   stim_rows [$];

    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;

    function automatic bit char_is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit char_is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit char_is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic lex_result_t make_result(input event_t kind, input token_t tok,
                                                input logic [7:0] text,
                                                input logic [VW-1:0] value,
                                                input logic [LW-1:0] line,
                                                input error_t err, input logic last);
        lex_result_t r;
        r.kind  = kind;
        r.tok   = tok;
        r.text  = text;
        r.value = value;
        r.line  = line;
        r.err   = err;
        r.last  = last;
        return r;
    endfunction

    function automatic void emit(input event_t kind, input token_t tok, input logic [7:0] text,
                                 input logic [VW-1:0] value, input error_t err);
        step_out.push_back(make_result(kind, tok, text, value, line_before, err, 1'b0));
    endfunction

    function automatic void count_line();
        if (line_count != LINE_MAX)
            line_count = line_count + 1'b1;
    endfunction

    function automatic void raise_error(input error_t code);
        held_err   = code;
        lex_mode_q = ST_ERROR;
        emit(EV_ERR, NO_TOKEN, 8'h00, '0, code);
    endfunction

    // An open token must be closed by the current character.
    function automatic void close_token(input token_t tok, input logic [VW-1:0] value,
                                        input error_t err, input logic [7:0] ch,
                                        input logic eot);
        if (eot)
        begin
            emit(EV_END, tok, 8'h00, value, NO_ERR);
            emit(EV_EOS, NO_TOKEN, 8'h00, '0, NO_ERR);
            lex_mode_q = ST_DONE;
        end
        else if (ch == CH_SEMI)
        begin
            emit(EV_END, tok, 8'h00, value, NO_ERR);
            emit(EV_SEMI, NO_TOKEN, 8'h00, '0, NO_ERR);
            lex_mode_q = ST_IDLE;
        end
        else if (char_is_space(ch))
        begin
            emit(EV_END, tok, 8'h00, value, NO_ERR);
            if (ch == CH_NL)
                count_line();
            lex_mode_q = ST_IDLE;
        end
        else
            raise_error(err);
    endfunction

    // Lexes one character into step_out; the newline count moves after the results.
    function automatic void lex_char(input logic [7:0] ch, input logic eot);
        longint unsigned digit;
        step_out.delete();
        line_before = line_count;
        digit = ch - CH_ZERO;
        case (lex_mode_q)
            ST_INT:
                if (!eot && char_is_digit(ch))
                begin
                    if (number_acc > (VALUE_MAX - digit) / 10)
                        number_acc = VALUE_MAX;
                    else
                        number_acc = number_acc * 10 + digit;
                    emit(EV_BYTE, TK_INT, ch, '0, NO_ERR);
                end
                else if (!eot && ch == CH_DOT)
                begin
                    emit(EV_BYTE, TK_DEC, ch, '0, NO_ERR);
                    lex_mode_q = ST_DEC;
                end
                else
                    close_token(TK_INT, number_acc, ERR_AFTER_NUM, ch, eot);
            ST_DEC:
                if (!eot && char_is_digit(ch))
                    emit(EV_BYTE, TK_DEC, ch, '0, NO_ERR);
                else
                    close_token(TK_DEC, '0, ERR_AFTER_NUM, ch, eot);
            ST_IDENT:
                if (!eot && (char_is_letter(ch) || char_is_digit(ch) || ch == CH_USCORE))
                    emit(EV_BYTE, TK_IDENT, ch, '0, NO_ERR);
                else
                    close_token(TK_IDENT, '0, ERR_AFTER_IDENT, ch, eot);
            ST_STR_DQ, ST_STR_SQ:
                if (eot)
                    raise_error(ERR_UNTERM_STR);
                else if (ch == ((lex_mode_q == ST_STR_DQ) ? CH_DQUOTE : CH_SQUOTE))
                    lex_mode_q = ST_AFTER_STR;
                else
                    emit(EV_BYTE, TK_STR, ch, '0, NO_ERR);
            ST_AFTER_STR:
                close_token(TK_STR, '0, ERR_AFTER_STR, ch, eot);
            ST_COMMENT:
                if (eot)
                begin
                    emit(EV_EOS, NO_TOKEN, 8'h00, '0, NO_ERR);
                    lex_mode_q = ST_DONE;
                end
                else if (ch == CH_NL)
                begin
                    count_line();
                    lex_mode_q = ST_IDLE;
                end
            ST_ERROR:
                emit(EV_ERR, NO_TOKEN, 8'h00, '0, held_err);
            ST_DONE:
                emit(EV_EOS, NO_TOKEN, 8'h00, '0, NO_ERR);
            default:
                if (eot)
                begin
                    emit(EV_EOS, NO_TOKEN, 8'h00, '0, NO_ERR);
                    lex_mode_q = ST_DONE;
                end
                else if (ch == CH_SEMI)
                    emit(EV_SEMI, NO_TOKEN, 8'h00, '0, NO_ERR);
                else if (char_is_digit(ch))
                begin
                    number_acc = VW'(digit);
                    emit(EV_BYTE, TK_INT, ch, '0, NO_ERR);
                    lex_mode_q = ST_INT;
                end
                else if (ch == CH_DQUOTE)
                    lex_mode_q = ST_STR_DQ;
                else if (ch == CH_SQUOTE)
                    lex_mode_q = ST_STR_SQ;
                else if (char_is_letter(ch))
                begin
                    emit(EV_BYTE, TK_IDENT, ch, '0, NO_ERR);
                    lex_mode_q = ST_IDENT;
                end
                else if (ch == CH_HASH)
                    lex_mode_q = ST_COMMENT;
                else if (char_is_space(ch))
                begin
                    if (ch == CH_NL)
                        count_line();
                end
                else
                    raise_error(ERR_UNEXPECTED);
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic eot);
        char_row_t r;
        r.ch      = ch;
        r.eot     = eot;
        r.typed   = 1'b0;
        r.n_typed = 0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_typed(input logic [7:0] ch, input int n,
                                      input lex_result_t first, input lex_result_t second);
        char_row_t r;
        r.ch           = ch;
        r.eot          = 1'b0;
        r.typed        = 1'b1;
        r.n_typed      = n;
        r.typed_res[0] = first;
        r.typed_res[1] = second;
        stim_rows.push_back(r);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(48, 57));
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] rand_space();
        return ($urandom_range(5) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    // Appends the text of one token; comments are left open.
    function automatic void add_token(input gen_kind_t kind);
        int         len;
        logic [7:0] c;
        logic [7:0] quote;
        case (kind)
            GEN_INT:
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
                repeat (len) add_row(rand_digit(), 1'b0);
            end
            GEN_DEC:
            begin
                repeat ($urandom_range(1, 4)) add_row(rand_digit(), 1'b0);
                add_row(CH_DOT, 1'b0);
                repeat ($urandom_range(0, 4)) add_row(rand_digit(), 1'b0);
            end
            GEN_IDENT:
            begin
                add_row(rand_letter(), 1'b0);
                repeat ($urandom_range(0, 8))
                begin
                    case ($urandom_range(3))
                        0:       add_row(rand_digit(), 1'b0);
                        1:       add_row(CH_USCORE, 1'b0);
                        default: add_row(rand_letter(), 1'b0);
                    endcase
                end
            end
            GEN_DQ, GEN_SQ:
            begin
                quote = (kind == GEN_DQ) ? CH_DQUOTE : CH_SQUOTE;
                add_row(quote, 1'b0);
                repeat ($urandom_range(0, 8))
                begin
                    do
                        c = 8'($urandom);
                    while (c == quote);
                    add_row(c, 1'b0);
                end
                add_row(quote, 1'b0);
            end
            default:
            begin
                add_row(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 10))
                begin
                    do
                        c = 8'($urandom);
                    while (c == CH_NL);
                    add_row(c, 1'b0);
                end
            end
        endcase
    endfunction

    // A character that neither continues nor closes what precedes it.
    function automatic logic [7:0] pick_bad(input gen_kind_t after);
        logic [7:0] c;
        bit         fits;
        do
        begin
            c    = 8'($urandom);
            fits = char_is_space(c) || c == CH_SEMI;
            case (after)
                GEN_INT:   fits = fits || char_is_digit(c) || c == CH_DOT;
                GEN_IDENT: fits = fits || char_is_digit(c) || char_is_letter(c) || c == CH_USCORE;
                GEN_NONE:  fits = fits || char_is_digit(c) || char_is_letter(c) ||
                                  c == CH_DQUOTE || c == CH_SQUOTE || c == CH_HASH;
                default:   ;
            endcase
        end
        while (fits);
        return c;
    endfunction

    function automatic int check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin : result_check
        lex_result_t want;
        if (rst_n && event_bus.valid && event_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation: event_kind %0d", event_bus.event_kind);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                fail_count += check_field("event_kind", want.kind, event_bus.event_kind);
                fail_count += check_field("token_kind", want.tok, event_bus.token_kind);
                fail_count += check_field("byte_out", want.text, event_bus.byte_out);
                fail_count += check_field("int_value", want.value, event_bus.int_value);
                fail_count += check_field("line_number", want.line, event_bus.line_number);
                fail_count += check_field("error_code", want.err, event_bus.error_code);
                fail_count += check_field("last_of_run", want.last, event_bus.last_of_run);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        event_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                event_bus.ready <= 1'b0;
            end
            else
                event_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        int stall_cycles;
        if (!rst_n || (char_bus.valid && char_bus.ready) || (event_bus.valid && event_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_config_text_lexer failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        char_row_t row;
        int        third;
        gen_kind_t kind;

        rst_n                <= 1'b0;
        char_bus.valid       <= 1'b0;
        char_bus.text_byte   <= 8'h00;
        char_bus.end_of_text <= 1'b0;

        // Directed stream: all on the first line until the string's newline.
        add_typed(CH_SEMI, 1,
                  make_result(EV_SEMI, NO_TOKEN, 8'h00, '0, FIRST_LINE, NO_ERR, 1'b1),
                  make_result(EV_SEMI, NO_TOKEN, 8'h00, '0, FIRST_LINE, NO_ERR, 1'b1));
        add_typed("9", 1,
                  make_result(EV_BYTE, TK_INT, "9", '0, FIRST_LINE, NO_ERR, 1'b1),
                  make_result(EV_BYTE, TK_INT, "9", '0, FIRST_LINE, NO_ERR, 1'b1));
        repeat (9) add_row("9", 1'b0);
        // Ten nines overflow the value field, so the value saturates.
        add_typed(CH_SEMI, 2,
                  make_result(EV_END, TK_INT, 8'h00, VALUE_MAX, FIRST_LINE, NO_ERR, 1'b0),
                  make_result(EV_SEMI, NO_TOKEN, 8'h00, '0, FIRST_LINE, NO_ERR, 1'b1));
        add_typed("Z", 1,
                  make_result(EV_BYTE, TK_IDENT, "Z", '0, FIRST_LINE, NO_ERR, 1'b1),
                  make_result(EV_BYTE, TK_IDENT, "Z", '0, FIRST_LINE, NO_ERR, 1'b1));
        add_row(CH_USCORE, 1'b0);
        add_row(CH_VT, 1'b0);
        add_row(CH_DQUOTE, 1'b0);
        add_typed(8'hFF, 1,
                  make_result(EV_BYTE, TK_STR, 8'hFF, '0, FIRST_LINE, NO_ERR, 1'b1),
                  make_result(EV_BYTE, TK_STR, 8'hFF, '0, FIRST_LINE, NO_ERR, 1'b1));
        add_row(CH_DQUOTE, 1'b0);
        add_row(CH_NL, 1'b0);
        add_row(CH_HASH, 1'b0);
        add_row(8'h80, 1'b0);
        add_row(CH_NL, 1'b0);
        add_row("5", 1'b0);
        add_row(CH_DOT, 1'b0);
        add_row(CH_SEMI, 1'b0);

        // Random well-formed tokens, each followed by a delimiter.
        while (stim_rows.size() < RANDOM_ITEMS - 20)
        begin
            if ($urandom_range(3) == 0)
                add_row(($urandom_range(2) == 0) ? CH_SEMI : rand_space(), 1'b0);
            kind = gen_kind_t'($urandom_range(5));
            add_token(kind);
            if (kind == GEN_COMMENT)
                add_row(CH_NL, 1'b0);
            else
                add_row(($urandom_range(2) == 0) ? CH_SEMI : rand_space(), 1'b0);
        end

        // One ending per run: end of text or a fault, which sticks.
        case ($urandom_range(7))
            0: add_row(8'($urandom), 1'b1);
            1:
            begin
                add_token(gen_kind_t'($urandom_range(4)));
                add_row(8'($urandom), 1'b1);
            end
            2:
            begin
                add_token(GEN_COMMENT);
                add_row(8'($urandom), 1'b1);
            end
            3: add_row(pick_bad(GEN_NONE), 1'b0);
            4:
            begin
                add_token($urandom_range(1) ? GEN_INT : GEN_DEC);
                add_row(pick_bad(GEN_INT), 1'b0);
            end
            5:
            begin
                add_token(GEN_IDENT);
                add_row(pick_bad(GEN_IDENT), 1'b0);
            end
            6:
            begin
                add_token($urandom_range(1) ? GEN_DQ : GEN_SQ);
                add_row(pick_bad(GEN_DQ), 1'b0);
            end
            default:
            begin
                // Drop the closing quote and end the text inside the string.
                add_token($urandom_range(1) ? GEN_DQ : GEN_SQ);
                void'(stim_rows.pop_back());
                add_row(8'($urandom), 1'b1);
            end
        endcase
        repeat (20) add_row(8'($urandom), $urandom_range(2) == 0);

        third = stim_rows.size() / 3;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int idx = 0; idx < stim_rows.size(); idx++)
        begin
            row = stim_rows[idx];
            if (idx < third)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 65;
            end
            else if (idx < 2 * third)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (idx == 2 * third)
                    hold_request = 1'b1;
            end

            while ($urandom_range(99) < send_idle_pct)
            begin
                char_bus.valid     <= 1'b0;
                char_bus.text_byte <= 8'($urandom);
                @(posedge clk);
            end
            char_bus.valid       <= 1'b1;
            char_bus.text_byte   <= row.ch;
            char_bus.end_of_text <= row.eot;
            do
                @(posedge clk);
            while (!char_bus.ready);

            // The transaction was accepted at this edge.
            lex_char(row.ch, row.eot);
            if (row.typed)
            begin
                for (int k = 0; k < row.n_typed; k++)
                    expected_results.push_back(row.typed_res[k]);
            end
            else
            begin
                foreach (step_out[k])
                    expected_results.push_back(step_out[k]);
            end
        end
        char_bus.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_config_text_lexer passed");
        else
            $display("tb_config_text_lexer failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/ctl_pkg.sv
design/ctl_if.sv
design/ctl_lex_core.sv
design/ctl_result_fifo.sv
design/config_text_lexer.sv
tb/tb_config_text_lexer.sv
